### hw/rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types, codes and parameter defaults for the sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int unsigned CAPACITY_DEF      = 16;
  localparam int unsigned PRIORITY_BITS_DEF = 16;
  localparam int unsigned PAYLOAD_BITS_DEF  = 32;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  // per-cell control from the queue controller
  typedef struct packed {
    logic do_insert;  // accepted insert, queue not full
    logic do_pop;     // accepted pop, queue not empty
    logic occupied;   // cell index below the entry count
  } cell_ctrl_t;

endpackage

### hw/rtl/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// behind the insertion point, shifts left on pop.
// ----------------------------------------------------------------------------
module sspq_cell #(
  parameter int unsigned PRIORITY_BITS = sspq_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS  = sspq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk,
  input  sspq_pkg::cell_ctrl_t            ctrl,
  input  logic signed [PRIORITY_BITS-1:0] new_prio,
  input  logic        [PAYLOAD_BITS-1:0]  new_payload,
  input  logic                            left_take,
  input  logic signed [PRIORITY_BITS-1:0] left_prio,
  input  logic        [PAYLOAD_BITS-1:0]  left_payload,
  input  logic signed [PRIORITY_BITS-1:0] right_prio,
  input  logic        [PAYLOAD_BITS-1:0]  right_payload,
  output logic                            take,
  output logic signed [PRIORITY_BITS-1:0] prio,
  output logic        [PAYLOAD_BITS-1:0]  payload
);

  logic signed [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic        [PAYLOAD_BITS-1:0]  payload_r, payload_nxt;

  // at or past the insertion point: empty, or holds a strictly larger priority
  assign take = !(ctrl.occupied && (prio_r <= new_prio));

  always_comb begin
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    if (ctrl.do_pop) begin
      prio_nxt    = right_prio;
      payload_nxt = right_payload;
    end else if (ctrl.do_insert && take) begin
      if (left_take) begin
        prio_nxt    = left_prio;
        payload_nxt = left_payload;
      end else begin
        prio_nxt    = new_prio;
        payload_nxt = new_payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

  assign prio    = prio_r;
  assign payload = payload_r;

endmodule

### hw/rtl/stable_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// Bounded stable min-priority queue built as a shift-register chain of cells.
// ----------------------------------------------------------------------------
// Takes one item (insert or pop) per clock while the receiver keeps up and
// returns one result item for each, registered, in the cycle after
// acceptance. Every cell compares the new priority against its own entry in
// the same cycle, so the whole chain shifts in one step. The output register
// is refilled in the cycle it drains, so items flow back to back while the
// receiver keeps up; a result held by the receiver holds off the request
// channel until it drains.
// Equal priorities leave in arrival order. Inserts on a full queue are
// dropped with error 1, pops on an empty queue report error 2.
// Entry storage has no reset; only the count and the result valid flag are cleared.
module stable_sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY      = sspq_pkg::CAPACITY_DEF,
  parameter int unsigned PRIORITY_BITS = sspq_pkg::PRIORITY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS  = sspq_pkg::PAYLOAD_BITS_DEF,
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic signed [PRIORITY_BITS-1:0] in_priority_req,
  input  logic        [PAYLOAD_BITS-1:0]  in_payload,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_popped_valid,
  output logic signed [PRIORITY_BITS-1:0] out_popped_priority,
  output logic        [PAYLOAD_BITS-1:0]  out_popped_payload,
  output logic signed [PRIORITY_BITS-1:0] out_head_priority,
  output logic        [PAYLOAD_BITS-1:0]  out_head_payload,
  output logic                            out_is_empty,
  output logic        [1:0]               out_error,
  output logic        [CNT_W-1:0]         out_occupancy
);

  // chain signals, one per cell
  logic                            take_w   [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] prio_w   [CAPACITY];
  logic        [PAYLOAD_BITS-1:0]  payload_w[CAPACITY];
  sspq_pkg::cell_ctrl_t            ctrl_w   [CAPACITY];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept, is_full, is_pop, do_insert, do_pop;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic                            popped_valid_r;
  logic signed [PRIORITY_BITS-1:0] popped_prio_r, popped_prio_nxt;
  logic        [PAYLOAD_BITS-1:0]  popped_payload_r, popped_payload_nxt;
  logic signed [PRIORITY_BITS-1:0] head_prio_r, head_prio_nxt;
  logic        [PAYLOAD_BITS-1:0]  head_payload_r, head_payload_nxt;
  sspq_pkg::err_t                  err_r, err_nxt;
  logic [CNT_W-1:0]                occ_r;

  // output register frees up when empty or being drained
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_pop    = (in_kind == sspq_pkg::KIND_POP);
  assign do_insert = accept && !is_pop && !is_full;
  assign do_pop    = accept && is_pop && (count_r != '0);

  // ---- cell chain ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                            lt;
    logic signed [PRIORITY_BITS-1:0] lp, rp;
    logic        [PAYLOAD_BITS-1:0]  lpl, rpl;

    assign ctrl_w[i].do_insert = do_insert;
    assign ctrl_w[i].do_pop    = do_pop;
    assign ctrl_w[i].occupied  = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign lt  = 1'b0;
      assign lp  = '0;
      assign lpl = '0;
    end else begin : g_mid
      assign lt  = take_w[i-1];
      assign lp  = prio_w[i-1];
      assign lpl = payload_w[i-1];
    end

    // last cell refills from itself on pop; its slot is past the count then
    if (i == CAPACITY - 1) begin : g_last
      assign rp  = prio_w[i];
      assign rpl = payload_w[i];
    end else begin : g_inner
      assign rp  = prio_w[i+1];
      assign rpl = payload_w[i+1];
    end

    sspq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl_w[i]),
      .new_prio     (in_priority_req),
      .new_payload  (in_payload),
      .left_take    (lt),
      .left_prio    (lp),
      .left_payload (lpl),
      .right_prio   (rp),
      .right_payload(rpl),
      .take         (take_w[i]),
      .prio         (prio_w[i]),
      .payload      (payload_w[i])
    );
  end

  // ---- entry count ----
  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // ---- result formation: head after the step ----
  always_comb begin
    popped_prio_nxt    = '0;
    popped_payload_nxt = '0;
    head_prio_nxt      = prio_w[0];
    head_payload_nxt   = payload_w[0];
    err_nxt            = sspq_pkg::ERR_NONE;
    if (is_pop) begin
      if (count_r == '0) begin
        err_nxt = sspq_pkg::ERR_EMPTY;
      end else begin
        popped_prio_nxt    = prio_w[0];
        popped_payload_nxt = payload_w[0];
        head_prio_nxt      = prio_w[1];
        head_payload_nxt   = payload_w[1];
      end
    end else if (is_full) begin
      err_nxt = sspq_pkg::ERR_FULL;
    end else if (take_w[0]) begin
      // new entry lands at the head
      head_prio_nxt    = in_priority_req;
      head_payload_nxt = in_payload;
    end
    // empty after the step: peek reads zero
    if (count_nxt == '0) begin
      head_prio_nxt    = '0;
      head_payload_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_valid_r   <= do_pop;
      popped_prio_r    <= popped_prio_nxt;
      popped_payload_r <= popped_payload_nxt;
      head_prio_r      <= head_prio_nxt;
      head_payload_r   <= head_payload_nxt;
      err_r            <= err_nxt;
      occ_r            <= count_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_popped_valid    = popped_valid_r;
  assign out_popped_priority = popped_prio_r;
  assign out_popped_payload  = popped_payload_r;
  assign out_head_priority   = head_prio_r;
  assign out_head_payload    = head_payload_r;
  assign out_is_empty        = (occ_r == '0);
  assign out_error           = err_r;
  assign out_occupancy       = occ_r;

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !accept)
    else $error("item accepted while result stalled");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && popped_valid_r) |-> (err_r == sspq_pkg::ERR_NONE))
    else $error("popped item flagged with error");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (occ_r == count_r))
    else $error("reported occupancy differs from entry count");

endmodule
